@@ hw/rtl/eect_pkg.sv @@
`default_nettype none
package eect_pkg;

    localparam int CMD_W  = 2;
    localparam int ADDR_W = 64;
    localparam int CNT_W  = 32;

    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RST   = 2'd2;

    localparam logic [CNT_W-1:0] MAX_ERR_RST = 32'd100;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic scan_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic scan_done;
        logic out_free;
    } t_dp_sts;

    typedef struct packed {
        logic              vld;
        logic              fam;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
        logic [CNT_W-1:0]  cnt;
    } t_entry;

endpackage
`default_nettype wire

@@ hw/rtl/eect_ctrl.sv @@
`default_nettype none
module eect_ctrl
    import eect_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_axis_tvalid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                o_cmd.load      = i_s_axis_tvalid;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            S_UPDATE: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_sts.out_free)
        else $error("commit while output register busy");

    a_load_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_SCAN))
        else $error("accepted item did not start a scan");

    a_scan_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.scan_step && i_sts.scan_done) |=> (r_state == S_UPDATE))
        else $error("finished scan did not go to update");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clr_step |-> !o_cmd.load && !o_cmd.commit)
        else $error("item handled during clearing pass");

endmodule
`default_nettype wire

@@ hw/rtl/eect_dp.sv @@
`default_nettype none
module eect_dp
    import eect_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_sts                 o_sts,
    input  wire logic               i_cfg_valid,
    input  wire logic [CNT_W-1:0]   i_cfg_data,
    input  wire logic [127:0]       i_s_axis_tdata,
    input  wire logic [2:0]         i_s_axis_tuser,
    input  wire logic               i_m_axis_tready,
    output logic                    o_m_axis_tvalid,
    output logic [CNT_W-1:0]        o_m_axis_tdata,
    output logic [1:0]              o_m_axis_tuser
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] LAST = CW'(ENTRIES - 1);
    localparam logic [CW-1:0] ENDX = CW'(ENTRIES);

    t_entry mem [ENTRIES];

    logic [CW-1:0]     r_idx;
    t_entry            r_q;
    logic [IW-1:0]     r_q_idx;
    logic              r_q_vld;
    logic [CMD_W-1:0]  r_cmd;
    logic              r_fam;
    logic [ADDR_W-1:0] r_hi;
    logic [ADDR_W-1:0] r_lo;
    logic              r_hit;
    logic [IW-1:0]     r_hit_idx;
    logic [CNT_W-1:0]  r_hit_cnt;
    logic              r_free_vld;
    logic [IW-1:0]     r_free_idx;
    logic [CNT_W-1:0]  r_max;
    logic              r_m_valid;
    logic [CNT_W-1:0]  r_m_count;
    logic              r_m_blocked;
    logic              r_m_full;

    logic [CNT_W-1:0]  n_res;
    logic [CNT_W-1:0]  n_stored;
    logic              n_full;
    logic              w_match;
    logic              w_we;
    logic [IW-1:0]     w_wa;
    t_entry            w_wd;

    // input fields
    logic [CMD_W-1:0]  w_in_cmd;
    logic              w_in_v6;
    logic [ADDR_W-1:0] w_in_hi;
    logic [ADDR_W-1:0] w_in_lo;

    assign w_in_cmd = i_s_axis_tuser[1:0];
    assign w_in_v6  = i_s_axis_tuser[2];
    assign w_in_hi  = i_s_axis_tdata[63:0];
    assign w_in_lo  = i_s_axis_tdata[127:64];

    assign w_match = r_q_vld && r_q.vld && (r_q.fam == r_fam) &&
                     (r_q.hi == r_hi) && (r_q.lo == r_lo);

    assign o_sts.clr_done  = (r_idx == LAST);
    assign o_sts.scan_done = r_q_vld && (w_match || (r_q_idx == LAST[IW-1:0]));
    assign o_sts.out_free  = !r_m_valid || i_m_axis_tready;

    always_comb begin
        n_res    = '0;
        n_stored = '0;
        n_full   = 1'b0;
        w_we     = 1'b0;
        w_wa     = r_idx[IW-1:0];
        w_wd     = '0;
        if (i_cmd.clr_step) begin
            w_we = 1'b1;
        end else if (i_cmd.commit) begin
            w_wd.vld = 1'b1;
            w_wd.fam = r_fam;
            w_wd.hi  = r_hi;
            w_wd.lo  = r_lo;
            case (r_cmd)
                CMD_INC: begin
                    if (r_hit) begin
                        n_res    = (&r_hit_cnt) ? r_hit_cnt : r_hit_cnt + CNT_W'(1);
                        n_stored = n_res;
                        w_we     = 1'b1;
                        w_wa     = r_hit_idx;
                        w_wd.cnt = n_res;
                    end else if (r_free_vld) begin
                        n_res    = CNT_W'(1);
                        n_stored = n_res;
                        w_we     = 1'b1;
                        w_wa     = r_free_idx;
                        w_wd.cnt = n_res;
                    end else begin
                        n_full = 1'b1;
                    end
                end
                CMD_RST: begin
                    if (r_hit) begin
                        n_res    = r_hit_cnt;
                        w_we     = 1'b1;
                        w_wa     = r_hit_idx;
                        w_wd.cnt = '0;
                    end
                end
                default: begin
                    n_res    = r_hit ? r_hit_cnt : '0;
                    n_stored = n_res;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_wa] <= w_wd;
        if (i_cmd.scan_step) r_q <= mem[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_q_vld    <= 1'b0;
            r_hit      <= 1'b0;
            r_free_vld <= 1'b0;
            r_max      <= MAX_ERR_RST;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) r_max <= i_cfg_data;
            if (i_cmd.clr_step) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.load) begin
                r_idx      <= '0;
                r_q_vld    <= 1'b0;
                r_hit      <= 1'b0;
                r_free_vld <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (r_idx != ENDX) r_idx <= r_idx + CW'(1);
                r_q_vld <= (r_idx != ENDX);
                if (w_match && !r_hit) r_hit <= 1'b1;
                if (r_q_vld && !r_q.vld && !r_free_vld) r_free_vld <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= w_in_cmd;
            r_fam <= w_in_v6;
            r_hi  <= w_in_v6 ? w_in_hi : '0;
            r_lo  <= w_in_v6 ? w_in_lo : {32'd0, w_in_lo[31:0]};
        end
        if (i_cmd.scan_step) begin
            r_q_idx <= r_idx[IW-1:0];
            if (w_match && !r_hit) begin
                r_hit_idx <= r_q_idx;
                r_hit_cnt <= r_q.cnt;
            end
            if (r_q_vld && !r_q.vld && !r_free_vld) r_free_idx <= r_q_idx;
        end
        if (i_cmd.commit) begin
            r_m_count   <= n_res;
            r_m_blocked <= (n_stored >= r_max);
            r_m_full    <= n_full;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_count;
    assign o_m_axis_tuser  = {r_m_full, r_m_blocked};

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_full) |-> (r_m_count == '0))
        else $error("table full result with nonzero count");

endmodule
`default_nettype wire

@@ hw/rtl/endpoint_error_counter_table.sv @@
// An item is looked up by a scan from index 0 that stops at the first matching
//   entry; a miss scans the whole table. The scan reads the entry memory one
//   entry per cycle, and no new item is accepted until the result of the last
//   one is committed to the output register.
// Reset: synchronous, active low; a clearing pass then marks every entry free,
//   with no item accepted; max_errors resets to 100.
`default_nettype none
module endpoint_error_counter_table
    import eect_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CNT_W-1:0]  i_cfg_data,      // max_errors
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [127:0]      i_s_axis_tdata,  // addr_hi[63:0], addr_lo[127:64]
    input  wire logic [2:0]        i_s_axis_tuser,  // cmd[1:0], is_v6[2]
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic [CNT_W-1:0]       o_m_axis_tdata,  // count[31:0]
    output logic [1:0]             o_m_axis_tuser   // blocked[0], table_full[1]
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    eect_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (w_sts),
        .o_cmd           (w_cmd)
    );

    eect_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
`default_nettype wire

@@ tb/endpoint_error_counter_table_test.sv @@
`timescale 1ns / 100ps
module endpoint_error_counter_table_test;
    import eect_pkg::*;

    localparam int ENTRIES    = 64;
    localparam int IDLE_LIMIT = 2000;
    localparam int POOL_SIZE  = 32;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam logic [ADDR_W-1:0] ONES64   = {ADDR_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic              v6;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
    } t_request;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             blocked;
        logic             full;
    } t_reply;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE
    } t_ready_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [CNT_W-1:0]   i_cfg_data = '0;
    logic               i_s_axis_tvalid = 1'b0;
    logic [127:0]       i_s_axis_tdata = '0;   // addr_hi[63:0], addr_lo[127:64]
    logic [2:0]         i_s_axis_tuser = '0;   // cmd[1:0], is_v6[2]
    logic               i_m_axis_tready = 1'b0;
    logic               o_cfg_ready;
    logic               o_s_axis_tready;
    logic               o_m_axis_tvalid;
    logic [CNT_W-1:0]   o_m_axis_tdata;        // count[31:0]
    logic [1:0]         o_m_axis_tuser;        // blocked[0], table_full[1]

    // shadow of the counter table
    bit                 tbl_used [ENTRIES];
    bit                 tbl_v6   [ENTRIES];
    bit [ADDR_W-1:0]    tbl_hi   [ENTRIES];
    bit [ADDR_W-1:0]    tbl_lo   [ENTRIES];
    bit [CNT_W-1:0]     tbl_cnt  [ENTRIES];
    int                 tbl_fill = 0;
    bit [CNT_W-1:0]     block_threshold = MAX_ERR_RST;

    t_reply             awaited_replies[$];
    t_request           key_pool [POOL_SIZE];
    int                 fail_count = 0;
    int                 burst_left = 0;
    int                 idle_cycles = 0;
    t_ready_mode        ready_mode = READY_ALWAYS;
    int                 ready_span = 0;

    endpoint_error_counter_table #(
        .ENTRIES(ENTRIES)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_reply apply_command(input t_request r);
        t_reply           rep;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
        int               hit;
        int               vacant;
        bit [CNT_W-1:0]   stored;
        hi = r.v6 ? r.hi : '0;
        lo = r.v6 ? r.lo : {32'd0, r.lo[31:0]};
        hit = -1;
        vacant = -1;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (tbl_used[i] && tbl_v6[i] == r.v6 && tbl_hi[i] == hi && tbl_lo[i] == lo)
                hit = i;
            if (!tbl_used[i])
                vacant = i;
        end
        rep = '0;
        stored = '0;
        case (r.cmd)
            CMD_INC: begin
                if (hit >= 0) begin
                    if (tbl_cnt[hit] != CNT_MAX)
                        tbl_cnt[hit] = tbl_cnt[hit] + 1;
                    rep.count = tbl_cnt[hit];
                    stored = tbl_cnt[hit];
                end else if (vacant < 0) begin
                    rep.full = 1'b1;
                end else begin
                    tbl_used[vacant] = 1'b1;
                    tbl_v6[vacant] = r.v6;
                    tbl_hi[vacant] = hi;
                    tbl_lo[vacant] = lo;
                    tbl_cnt[vacant] = 1;
                    tbl_fill++;
                    rep.count = 1;
                    stored = 1;
                end
            end
            CMD_RST: begin
                if (hit >= 0) begin
                    rep.count = tbl_cnt[hit];
                    tbl_cnt[hit] = '0;
                end
            end
            default: begin
                if (hit >= 0)
                    rep.count = tbl_cnt[hit];
                stored = rep.count;
            end
        endcase
        rep.blocked = (stored >= block_threshold);
        return rep;
    endfunction

    function automatic t_request make_request(input logic [CMD_W-1:0] cmd, input logic v6,
                                              input logic [ADDR_W-1:0] hi,
                                              input logic [ADDR_W-1:0] lo);
        t_request r;
        r.cmd = cmd;
        r.v6 = v6;
        r.hi = hi;
        r.lo = lo;
        return r;
    endfunction

    function automatic t_request random_address();
        return make_request(CMD_QUERY, $urandom_range(0, 9) < 6,
                            {$urandom, $urandom}, {$urandom, $urandom});
    endfunction

    task automatic send_request(input t_request r);
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {r.lo, r.hi};
        i_s_axis_tuser <= {r.v6, r.cmd};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        awaited_replies = {awaited_replies, apply_command(r)};
        burst_left--;
    endtask

    task automatic wait_replies();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (awaited_replies.size() != 0);
        burst_left = $urandom_range(1, 16);
    endtask

    task automatic write_threshold(input logic [CNT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        block_threshold = value;
    endtask

    task automatic test_directed_commands();
        send_request(make_request(CMD_QUERY, 1'b0, '0, '0));
        send_request(make_request(CMD_RST, 1'b1, ONES64, ONES64));
        // IPv4 ignores addr_hi and the upper half of addr_lo
        send_request(make_request(CMD_INC, 1'b0, ONES64, ONES64));
        send_request(make_request(CMD_QUERY, 1'b0, '0, 64'h0000_0000_FFFF_FFFF));
        send_request(make_request(CMD_INC, 1'b0, {32{2'b01}}, 64'hA5A5_A5A5_FFFF_FFFF));
        send_request(make_request(CMD_INC, 1'b1, '0, 64'h0000_0000_FFFF_FFFF));
        send_request(make_request(CMD_INC, 1'b1, ONES64, ONES64));
        send_request(make_request(CMD_INC, 1'b1, '0, '0));
        send_request(make_request(CMD_INC, 1'b0, '0, '0));
        send_request(make_request(CMD_SPARE, 1'b0, '0, 64'hFFFF_FFFF));
        send_request(make_request(CMD_RST, 1'b0, '0, 64'hFFFF_FFFF));
        send_request(make_request(CMD_QUERY, 1'b0, '0, 64'hFFFF_FFFF));
        send_request(make_request(CMD_INC, 1'b0, '0, 64'hFFFF_FFFF));
        send_request(make_request(CMD_QUERY, 1'b1, ONES64, '0));
        send_request(make_request(CMD_SPARE, 1'b1, 64'h1, 64'h2));
    endtask

    task automatic test_threshold();
        wait_replies();
        write_threshold('0);
        send_request(make_request(CMD_QUERY, 1'b1, 64'h1234, 64'h5678));
        send_request(make_request(CMD_RST, 1'b0, '0, '0));
        send_request(make_request(CMD_INC, 1'b0, '0, '0));
        wait_replies();
        write_threshold(32'd1);
        send_request(make_request(CMD_RST, 1'b0, '0, '0));
        send_request(make_request(CMD_INC, 1'b0, '0, '0));
        send_request(make_request(CMD_QUERY, 1'b1, 64'h1234, 64'h5678));
        wait_replies();
        write_threshold(CNT_MAX);
        send_request(make_request(CMD_INC, 1'b1, ONES64, ONES64));
        send_request(make_request(CMD_QUERY, 1'b1, ONES64, ONES64));
    endtask

    task automatic test_random_traffic(input int n, input logic [CNT_W-1:0] limit);
        t_request r;
        int       pick;
        wait_replies();
        write_threshold(limit);
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 9);
            if ($urandom_range(0, 4) == 0)
                r = random_address();
            else
                r = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            r.cmd = pick < 5 ? CMD_INC : pick < 7 ? CMD_QUERY : pick < 9 ? CMD_RST : CMD_SPARE;
            if (!r.v6) begin
                r.hi = {$urandom, $urandom};
                r.lo[63:32] = $urandom;
            end
            send_request(r);
        end
    endtask

    task automatic test_full_table();
        t_request r;
        while (tbl_fill < ENTRIES) begin
            r = random_address();
            r.cmd = CMD_INC;
            send_request(r);
        end
        r = random_address();
        r.v6 = 1'b1;
        r.cmd = CMD_INC;
        send_request(r);
        r.v6 = 1'b0;
        send_request(r);
        r.cmd = CMD_QUERY;
        send_request(r);
        r.cmd = CMD_RST;
        send_request(r);
        send_request(make_request(CMD_INC, 1'b1, ONES64, ONES64));
    endtask

    always @(posedge i_clk) begin
        if (ready_span == 0) begin
            ready_mode <= t_ready_mode'($urandom_range(0, 2));
            ready_span <= $urandom_range(8, 48);
        end else begin
            ready_span <= ready_span - 1;
        end
        case (ready_mode)
            READY_ALWAYS: i_m_axis_tready <= 1'b1;
            READY_COIN:   i_m_axis_tready <= 1'($urandom_range(0, 1));
            default:      i_m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (awaited_replies.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected item, expected none actual count %0d flags %b",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
            end else begin
                want = awaited_replies.pop_front();
                if (o_m_axis_tdata !== want.count) begin
                    fail_count++;
                    $display("%0t: count expected %0d actual %0d",
                             $time, want.count, o_m_axis_tdata);
                end
                if (o_m_axis_tuser[0] !== want.blocked) begin
                    fail_count++;
                    $display("%0t: blocked expected %b actual %b",
                             $time, want.blocked, o_m_axis_tuser[0]);
                end
                if (o_m_axis_tuser[1] !== want.full) begin
                    fail_count++;
                    $display("%0t: table_full expected %b actual %b",
                             $time, want.full, o_m_axis_tuser[1]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        foreach (key_pool[i])
            key_pool[i] = random_address();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_commands();
        test_threshold();
        test_random_traffic(200, 32'd3);
        test_full_table();
        test_random_traffic(150, 32'd2);
        wait_replies();
        repeat (ENTRIES + 8) @(posedge i_clk);
        if (fail_count == 0 && awaited_replies.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
